// ===== hw/rtl/bmc_edge_timing_decoder_defines.svh =====
// Assertion helpers for the edge timing decoder.
`ifndef BMC_EDGE_TIMING_DECODER_DEFINES_SVH
`define BMC_EDGE_TIMING_DECODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bmc_pkg.sv =====
`default_nettype none

package bmc_pkg;

    // Receiver mode
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HUNT = 2'd1,
        MODE_DATA = 2'd2
    } t_mode;

    // Request kind
    typedef enum logic [1:0] {
        KIND_EDGE    = 2'd0,
        KIND_HUNT    = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    // Result status
    typedef enum logic [2:0] {
        ST_SYMBOL  = 3'd0,
        ST_SYNC    = 3'd1,
        ST_HARD    = 3'd2,
        ST_CABLE   = 3'd3,
        ST_BAD     = 3'd4,
        ST_TIMEOUT = 3'd5,
        ST_LIMIT   = 3'd6
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SHORT_THRESHOLD = 2'd0,
        CFG_MAX_INTERVAL    = 2'd1,
        CFG_SYMBOL_BITS     = 2'd2,
        CFG_EDGE_LIMIT      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_status     status;
        logic [31:0] symbol;
    } t_result;

    // Signatures seen in the half-bit pattern (1 = short interval)
    localparam logic [31:0] SIG_SYNC        = 32'h36db6db6;
    localparam logic [31:0] SIG_HARD_RESET  = 32'hF33F3F3F;
    localparam logic [31:0] SIG_CABLE_RESET = 32'h3c7fe0ff;

    // Register defaults
    localparam logic [7:0] RST_SHORT_THRESHOLD = 8'd6;
    localparam logic [7:0] RST_MAX_INTERVAL    = 8'd12;
    localparam logic [5:0] RST_SYMBOL_BITS     = 6'd5;
    localparam logic [9:0] RST_EDGE_LIMIT      = 10'd858;

    // Bits already counted when data mode starts
    localparam logic [5:0] SYNC_BIT_COUNT = 6'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/bmc_in_if.sv =====
`default_nettype none

interface bmc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] timestamp;

    modport source (output valid, output kind, output timestamp, input ready);
    modport sink (input valid, input kind, input timestamp, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmc_out_if.sv =====
`default_nettype none

interface bmc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] symbol;

    modport source (output valid, output status, output symbol, input ready);
    modport sink (input valid, input status, input symbol, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmc_edge_timing_decoder.sv =====
// A result is written into the result queue as its request is accepted and is offered
// behind any earlier results. Throughput: one request per cycle while the queue has
// room; the interval subtract, threshold compares and shifts all settle between the
// input handshake and a two-entry result queue. Input ready drops only while both
// queue entries hold results not yet taken. Reset (synchronous, active low) returns
// to idle mode, empties the queue and loads the register defaults.
`default_nettype none

`include "bmc_edge_timing_decoder_defines.svh"

module bmc_edge_timing_decoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bmc_in_if.sink     i_in,
    bmc_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [1:0]  i_cfg_idx,
    input  wire [9:0]  i_cfg_data
);
    import bmc_pkg::*;

    // Configuration registers
    logic [7:0] r_short;
    logic [7:0] r_max;
    logic [5:0] r_symbol_bits;
    logic [9:0] r_limit;

    // Decoder state
    t_mode       r_mode, n_mode;
    logic [7:0]  r_prev, n_prev;
    logic        r_have, n_have;
    logic [31:0] r_pattern, n_pattern;
    logic        r_half, n_half;
    logic [31:0] r_bits, n_bits;
    logic [5:0]  r_bit_count, n_bit_count;
    logic [9:0]  r_edge, n_edge;

    // Result queue
    t_result     r_fifo [2];
    logic        r_rd;
    logic [1:0]  r_count;

    logic        accept;
    logic        pop;
    logic        push;
    t_result     result;
    logic        wr;

    logic [7:0]  interval;
    logic        is_short;
    logic [31:0] pattern_next;
    logic [10:0] edge_sum;
    logic        limit_hit;
    logic [5:0]  sb;
    logic [31:0] sym_mask;
    logic [5:0]  count_inc;

    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_out.valid && o_out.ready;
    assign wr     = r_rd ^ r_count[0];

    assign i_in.ready   = (r_count != 2'd2);
    assign o_out.valid  = (r_count != 2'd0);
    assign o_out.status = r_fifo[r_rd].status;
    assign o_out.symbol = r_fifo[r_rd].symbol;

    // Interval and classification
    assign interval     = i_in.timestamp - r_prev;
    assign is_short     = (interval <= r_short);
    assign pattern_next = {is_short, r_pattern[31:1]};
    assign edge_sum     = {1'b0, r_edge} + 11'd1;
    assign limit_hit    = (edge_sum >= {1'b0, r_limit});

    // Clamp symbol size to 1..32
    always_comb begin
        if (r_symbol_bits == 6'd0) begin
            sb = 6'd1;
        end else if (r_symbol_bits > 6'd32) begin
            sb = 6'd32;
        end else begin
            sb = r_symbol_bits;
        end
    end

    assign sym_mask  = ~(32'hFFFF_FFFF << sb);
    assign count_inc = r_bit_count + 6'd1;

    // Next state and result
    always_comb begin
        logic        v_take;
        logic        v_bit;
        logic [31:0] v_bits;

        n_mode      = r_mode;
        n_prev      = r_prev;
        n_have      = r_have;
        n_pattern   = r_pattern;
        n_half      = r_half;
        n_bits      = r_bits;
        n_bit_count = r_bit_count;
        n_edge      = r_edge;
        push          = 1'b0;
        result.status = ST_SYMBOL;
        result.symbol = 32'd0;
        v_take = 1'b0;
        v_bit  = 1'b0;
        v_bits = r_bits | ({31'd0, is_short && r_half} << r_bit_count[4:0]);

        if (accept) begin
            case (i_in.kind)
                KIND_HUNT: begin
                    n_mode      = MODE_HUNT;
                    n_have      = 1'b0;
                    n_pattern   = 32'd0;
                    n_half      = 1'b0;
                    n_bits      = 32'd0;
                    n_bit_count = 6'd0;
                    n_edge      = 10'd0;
                end
                KIND_TIMEOUT: begin
                    if (r_mode == MODE_HUNT || r_mode == MODE_DATA) begin
                        n_mode        = MODE_IDLE;
                        n_half        = 1'b0;
                        push          = 1'b1;
                        result.status = ST_TIMEOUT;
                    end
                end
                KIND_EDGE: begin
                    if (r_mode == MODE_HUNT || r_mode == MODE_DATA) begin
                        if (limit_hit) begin
                            n_mode        = MODE_IDLE;
                            n_half        = 1'b0;
                            push          = 1'b1;
                            result.status = ST_LIMIT;
                        end else begin
                            n_edge = edge_sum[9:0];
                            n_prev = i_in.timestamp;
                            if (!r_have) begin
                                n_have = 1'b1;
                            end else if (r_mode == MODE_HUNT) begin
                                // Shift in the half-bit class and match signatures
                                n_pattern = pattern_next;
                                if (pattern_next == SIG_SYNC) begin
                                    n_mode        = MODE_DATA;
                                    n_half        = 1'b0;
                                    n_bits        = 32'd0;
                                    n_bit_count   = SYNC_BIT_COUNT;
                                    push          = 1'b1;
                                    result.status = ST_SYNC;
                                end else if (pattern_next == SIG_HARD_RESET) begin
                                    n_mode        = MODE_IDLE;
                                    n_half        = 1'b0;
                                    push          = 1'b1;
                                    result.status = ST_HARD;
                                end else if (pattern_next == SIG_CABLE_RESET) begin
                                    n_mode        = MODE_IDLE;
                                    n_half        = 1'b0;
                                    push          = 1'b1;
                                    result.status = ST_CABLE;
                                end
                            end else begin
                                // Data mode: long interval is 0, two short ones are 1
                                if (!r_half) begin
                                    if (interval == 8'd0 || interval > r_max) begin
                                        n_mode        = MODE_IDLE;
                                        push          = 1'b1;
                                        result.status = ST_BAD;
                                    end else if (is_short) begin
                                        n_half = 1'b1;
                                    end else begin
                                        v_take = 1'b1;
                                    end
                                end else begin
                                    n_half = 1'b0;
                                    if (!is_short) begin
                                        n_mode        = MODE_IDLE;
                                        push          = 1'b1;
                                        result.status = ST_BAD;
                                    end else begin
                                        v_take = 1'b1;
                                        v_bit  = 1'b1;
                                    end
                                end
                                if (v_take) begin
                                    v_bits      = r_bits | ({31'd0, v_bit} << r_bit_count[4:0]);
                                    n_bits      = v_bits;
                                    n_bit_count = count_inc;
                                    if (count_inc >= sb) begin
                                        push          = 1'b1;
                                        result.status = ST_SYMBOL;
                                        result.symbol = v_bits & sym_mask;
                                        n_bits        = v_bits >> sb;
                                        n_bit_count   = count_inc - sb;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short       <= RST_SHORT_THRESHOLD;
            r_max         <= RST_MAX_INTERVAL;
            r_symbol_bits <= RST_SYMBOL_BITS;
            r_limit       <= RST_EDGE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHORT_THRESHOLD: r_short       <= i_cfg_data[7:0];
                CFG_MAX_INTERVAL:    r_max         <= i_cfg_data[7:0];
                CFG_SYMBOL_BITS:     r_symbol_bits <= i_cfg_data[5:0];
                CFG_EDGE_LIMIT:      r_limit       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_prev      <= 8'd0;
            r_have      <= 1'b0;
            r_pattern   <= 32'd0;
            r_half      <= 1'b0;
            r_bits      <= 32'd0;
            r_bit_count <= 6'd0;
            r_edge      <= 10'd0;
        end else begin
            r_mode      <= n_mode;
            r_prev      <= n_prev;
            r_have      <= n_have;
            r_pattern   <= n_pattern;
            r_half      <= n_half;
            r_bits      <= n_bits;
            r_bit_count <= n_bit_count;
            r_edge      <= n_edge;
        end
    end

    // Result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Result queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[wr] <= result;
        end
    end

    `BMC_ASSERT_ALWAYS(a_reset_empties_queue, !i_rst_n |=> r_count == 2'd0, "queue not empty after reset")
    `BMC_ASSERT(a_pop_drains, (pop && !push) |=> r_count == $past(r_count) - 2'd1, "queue count off after pop")
    `BMC_ASSERT(a_symbol_only_data, (o_out.valid && o_out.status != ST_SYMBOL) |-> o_out.symbol == 32'd0, "symbol set on non-symbol status")
    `BMC_ASSERT(a_sync_enters_data, (push && result.status == ST_SYNC) |=> (r_mode == MODE_DATA && r_bit_count == SYNC_BIT_COUNT), "sync did not enter data mode")

endmodule

`default_nettype wire
